// ===== hw/rtl/cba_pkg.sv =====
// Package with the types and constants shared by the contiguous block allocator files.
package cba_pkg;

  localparam int LEN_W       = 27;
  localparam int START_W     = 12;
  localparam int RUN_W       = 12;
  localparam int STATUS_W    = 2;
  localparam int BLOCK_BYTES = 16384;
  localparam int BLOCK_SHIFT = 14;
  localparam int NBLK_W      = LEN_W - BLOCK_SHIFT + 1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BADARG  = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_WRITE
  } state_t;

endpackage

// ===== hw/rtl/contiguous_block_allocator_top.sv =====
// Top level of the contiguous first-fit block allocator with its used map memory.
//
// A request is taken at a rising edge where start is high and busy is low. kind selects
// allocate or free, byte_length is rounded up to whole 16384-byte blocks, and start_block
// gives the first block of a run to free. Exactly one result follows each request: done is
// high for one cycle with status, run_start and run_blocks, and the receiver cannot stall it.
// A request with a zero length, a free out of bounds, or an allocate of more than
// TOTAL_BLOCKS - 1 blocks is answered in the cycle after it is taken. An allocate walks the
// used map one block per cycle from block 1 through a single read port and then marks the
// run one block per cycle. A free writes one block per cycle. The map memory has one write
// and one read port; its sequential scan sets the rate. After reset the block sweeps the
// map to all free, one entry per cycle, holding busy high until the sweep is done; only
// then is the first request taken.
module contiguous_block_allocator_top #(
  parameter int TOTAL_BLOCKS = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [cba_pkg::LEN_W-1:0]     byte_length,
  input  logic [cba_pkg::START_W-1:0]   start_block,
  output logic                          done,
  output logic [cba_pkg::STATUS_W-1:0]  status,
  output logic [cba_pkg::RUN_W-1:0]     run_start,
  output logic [cba_pkg::RUN_W-1:0]     run_blocks
);
  import cba_pkg::*;

  localparam int AW  = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
  localparam int CW  = $clog2(TOTAL_BLOCKS + 1);
  localparam int WW  = ((CW > NBLK_W) ? CW : NBLK_W) + 1;
  localparam logic [WW-1:0] TB_W   = WW'(TOTAL_BLOCKS);
  localparam logic [WW-1:0] LAST_W = WW'(TOTAL_BLOCKS - 1);

  state_t state, state_next;

  logic [WW-1:0]       cur, cur_next;
  logic [NBLK_W-1:0]   remaining, remaining_next;
  logic [NBLK_W-1:0]   nblk, nblk_next;
  logic [WW-1:0]       scan, scan_next;
  logic [WW-1:0]       eval_addr, eval_addr_next;
  logic [WW-1:0]       run_len, run_len_next;
  logic                pend, pend_next;
  logic                wr_val, wr_val_next;
  logic                done_next;
  logic [STATUS_W-1:0] status_next;
  logic [RUN_W-1:0]    run_start_next, run_blocks_next;

  logic                mem [TOTAL_BLOCKS];
  logic                rd_data;
  logic                rd_en;
  logic                wr_en;
  logic                wr_data;

  logic [LEN_W:0]      len_round;
  logic [NBLK_W-1:0]   req_blocks;
  logic [WW-1:0]       req_blocks_w;
  logic [WW-1:0]       start_w;
  logic [WW-1:0]       run_inc;
  logic [WW-1:0]       first;
  logic                hit;

  assign len_round    = {1'b0, byte_length} + (LEN_W + 1)'(BLOCK_BYTES - 1);
  assign req_blocks   = len_round[LEN_W:BLOCK_SHIFT];
  assign req_blocks_w = WW'(req_blocks);
  assign start_w      = WW'(start_block);
  assign run_inc      = run_len + WW'(1);
  assign hit          = pend && !rd_data && (run_inc == WW'(nblk));
  assign first        = eval_addr - WW'(nblk) + WW'(1);

  assign busy    = (state != ST_IDLE);
  assign rd_en   = (state == ST_SEARCH) && (scan < TB_W);
  assign wr_en   = (state == ST_CLEAR) || (state == ST_WRITE);
  assign wr_data = (state == ST_CLEAR) ? 1'b0 : wr_val;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[scan[AW-1:0]];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cur == LAST_W) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && req_blocks != '0) begin
          if (kind == KIND_ALLOC) begin
            if (req_blocks_w <= LAST_W) state_next = ST_SEARCH;
          end else if (start_w != '0 && start_w + req_blocks_w <= TB_W) begin
            state_next = ST_WRITE;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) state_next = ST_WRITE;
        else if (pend && eval_addr == LAST_W) state_next = ST_IDLE;
      end
      ST_WRITE: begin
        if (remaining == NBLK_W'(1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_next        = cur;
    remaining_next  = remaining;
    nblk_next       = nblk;
    scan_next       = scan;
    eval_addr_next  = eval_addr;
    run_len_next    = run_len;
    pend_next       = 1'b0;
    wr_val_next     = wr_val;
    done_next       = 1'b0;
    status_next     = status;
    run_start_next  = run_start;
    run_blocks_next = run_blocks;
    case (state)
      ST_CLEAR: begin
        cur_next = cur + WW'(1);
      end
      ST_IDLE: begin
        if (start) begin
          nblk_next    = req_blocks;
          scan_next    = WW'(1);
          run_len_next = '0;
          if (req_blocks == '0) begin
            done_next       = 1'b1;
            status_next     = STATUS_BADARG;
            run_start_next  = '0;
            run_blocks_next = '0;
          end else if (kind == KIND_ALLOC) begin
            if (req_blocks_w > LAST_W) begin
              done_next       = 1'b1;
              status_next     = STATUS_NOSPACE;
              run_start_next  = '0;
              run_blocks_next = '0;
            end
          end else if (start_w == '0 || start_w + req_blocks_w > TB_W) begin
            done_next       = 1'b1;
            status_next     = STATUS_BADARG;
            run_start_next  = '0;
            run_blocks_next = '0;
          end else begin
            cur_next        = start_w;
            remaining_next  = req_blocks;
            wr_val_next     = 1'b0;
            status_next     = STATUS_DONE;
            run_start_next  = start_block;
            run_blocks_next = req_blocks[RUN_W-1:0];
          end
        end
      end
      ST_SEARCH: begin
        if (scan < TB_W) begin
          pend_next      = 1'b1;
          eval_addr_next = scan;
          scan_next      = scan + WW'(1);
        end
        if (pend) begin
          run_len_next = rd_data ? '0 : run_inc;
        end
        if (hit) begin
          pend_next       = 1'b0;
          cur_next        = first;
          remaining_next  = nblk;
          wr_val_next     = 1'b1;
          status_next     = STATUS_DONE;
          run_start_next  = first[RUN_W-1:0];
          run_blocks_next = nblk[RUN_W-1:0];
        end else if (pend && eval_addr == LAST_W) begin
          pend_next       = 1'b0;
          done_next       = 1'b1;
          status_next     = STATUS_NOSPACE;
          run_start_next  = '0;
          run_blocks_next = '0;
        end
      end
      ST_WRITE: begin
        cur_next       = cur + WW'(1);
        remaining_next = remaining - NBLK_W'(1);
        if (remaining == NBLK_W'(1)) done_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cur   <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    remaining  <= remaining_next;
    nblk       <= nblk_next;
    scan       <= scan_next;
    eval_addr  <= eval_addr_next;
    run_len    <= run_len_next;
    wr_val     <= wr_val_next;
    status     <= status_next;
    run_start  <= run_start_next;
    run_blocks <= run_blocks_next;
  end

endmodule

// ===== hw/rtl/cba_checker.sv =====
// Port-level checker for the contiguous block allocator and its bind to the top level.
module cba_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [cba_pkg::STATUS_W-1:0]  status,
  input logic [cba_pkg::RUN_W-1:0]     run_start,
  input logic [cba_pkg::RUN_W-1:0]     run_blocks
);
  import cba_pkg::*;

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STATUS_DONE || status == STATUS_NOSPACE || status == STATUS_BADARG))
    else $error("result status holds an undefined code");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_DONE) |-> (run_start == '0 && run_blocks == '0))
    else $error("failed request reports a nonzero run");

  a_request_taken: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request neither started work nor produced a result");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    (busy && !$past(busy) && !$past(rst)) |-> !done)
    else $error("result strobe raised in the cycle work began");

endmodule

bind contiguous_block_allocator_top cba_checker u_cba_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .run_start  (run_start),
  .run_blocks (run_blocks)
);
